// ===== hw/rtl/bchd_pkg.sv =====
// Shared constants for the button click / hold detector.
`default_nettype none

package bchd_pkg;

  // Default timer width in bits
  localparam int unsigned TimerWidthDef = 16;

  // Config port geometry
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned TickW     = 8;
  localparam int unsigned ThrW      = 16;

  // Register indexes
  localparam logic [CfgIndexW-1:0] CFG_TICK_PERIOD = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_HOLD_THR    = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_INTERVAL    = 2'd2;

  // Register reset values
  localparam logic [TickW-1:0] TICK_PERIOD_RST = 8'd10;
  localparam logic [ThrW-1:0]  HOLD_THR_RST    = 16'd1000;
  localparam logic [ThrW-1:0]  INTERVAL_RST    = 16'd300;

  // Key phase codes
  localparam logic [1:0] PHASE_DOWN = 2'd0;
  localparam logic [1:0] PHASE_LOW  = 2'd1;
  localparam logic [1:0] PHASE_UP   = 2'd2;
  localparam logic [1:0] PHASE_HIGH = 2'd3;

  // Click kind codes
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_DOUBLE = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/button_click_hold_detector.sv =====
// Top level of the button click / hold detector for one active-low key.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------------
//   in       | in_valid_i / in_stall_o   | pin_level_i
//   out      | out_valid_o / out_stall_i | key_phase_o, press_event_o, hold_active_o,
//            |                           | double_click_o, up_event_o,
//            |                           | released_level_o, click_kind_o
//   cfg      | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One input transaction yields exactly one output transaction.
// The result lands in the output register at the accept edge.
// Throughput is one transaction per cycle while no result is stalled, set by the single output register.
// in_stall_o is high only while a result sits in the output register and is stalled.
// Reset puts the key at released, clears timers and click wait, loads register defaults.
`default_nettype none

module button_click_hold_detector
  import bchd_pkg::*;
#(
  parameter int unsigned TimerWidth = TimerWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // config write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  // pin sample channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 pin_level_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                key_phase_o,
  output logic                      press_event_o,
  output logic                      hold_active_o,
  output logic                      double_click_o,
  output logic                      up_event_o,
  output logic                      released_level_o,
  output logic [1:0]                click_kind_o
);

  // Compare width: wide enough for both a timer and a 16-bit threshold
  localparam int unsigned CmpW = (TimerWidth > ThrW) ? TimerWidth : ThrW;

  // Config registers
  logic [TickW-1:0] tick_q;
  logic [ThrW-1:0]  hold_thr_q;
  logic [ThrW-1:0]  interval_q;

  // Key state
  logic                  level_q, level_d;
  logic [TimerWidth-1:0] hold_q, hold_d;
  logic [TimerWidth-1:0] gap_q, gap_d;
  logic                  pending_q, pending_d;

  // Output register
  logic       out_valid_q;
  logic [1:0] phase_q, phase_d;
  logic       press_q, press_d;
  logic       hold_act_q, hold_act_d;
  logic       dbl_q, dbl_d;
  logic       up_q, up_d;
  logic       rel_q, rel_d;
  logic [1:0] kind_q, kind_d;

  logic                  accept;
  logic [TimerWidth:0]   hold_sum, gap_sum;
  logic [TimerWidth-1:0] hold_inc, gap_inc;

  // The output register frees up when empty or when its result is taken
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Config writes, masked to register width; unused index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= TICK_PERIOD_RST;
      hold_thr_q <= HOLD_THR_RST;
      interval_q <= INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TICK_PERIOD: tick_q     <= cfg_data_i[TickW-1:0];
        CFG_HOLD_THR:    hold_thr_q <= cfg_data_i[ThrW-1:0];
        CFG_INTERVAL:    interval_q <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Saturating timer increments
  assign hold_sum = {1'b0, hold_q} + (TimerWidth+1)'(tick_q);
  assign gap_sum  = {1'b0, gap_q} + (TimerWidth+1)'(tick_q);
  assign hold_inc = hold_sum[TimerWidth] ? '1 : hold_sum[TimerWidth-1:0];
  assign gap_inc  = gap_sum[TimerWidth] ? '1 : gap_sum[TimerWidth-1:0];

  always_comb begin
    level_d    = pin_level_i;
    hold_d     = hold_q;
    gap_d      = gap_q;
    pending_d  = pending_q;
    press_d    = 1'b0;
    hold_act_d = 1'b0;
    dbl_d      = 1'b0;
    up_d       = 1'b0;
    rel_d      = 1'b0;
    kind_d     = KIND_NONE;
    phase_d    = {pin_level_i, ~(level_q ^ pin_level_i)};

    unique case (phase_d)
      PHASE_DOWN: begin
        press_d = 1'b1;
        hold_d  = '0;
        if (!pending_q) begin
          kind_d    = KIND_SINGLE;
          pending_d = 1'b1;
        end else if (CmpW'(gap_q) <= CmpW'(interval_q)) begin
          dbl_d     = 1'b1;
          kind_d    = KIND_DOUBLE;
          pending_d = 1'b0;
        end
      end
      PHASE_LOW: begin
        hold_d = hold_inc;
        if (CmpW'(hold_inc) >= CmpW'(hold_thr_q)) begin
          hold_act_d = 1'b1;
          pending_d  = 1'b0;
        end
      end
      PHASE_UP: begin
        up_d = 1'b1;
        if (pending_q) gap_d = '0;
      end
      PHASE_HIGH: begin
        rel_d = 1'b1;
        if (pending_q) begin
          // wait ends once the release gap passes the interval
          if (CmpW'(gap_inc) > CmpW'(interval_q)) begin
            pending_d = 1'b0;
            gap_d     = '0;
          end else begin
            gap_d = gap_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= 1'b1;
      hold_q      <= '0;
      gap_q       <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        level_q   <= level_d;
        hold_q    <= hold_d;
        gap_q     <= gap_d;
        pending_q <= pending_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded only on accept so a stalled result holds
  always_ff @(posedge clk_i) begin
    if (accept) begin
      phase_q    <= phase_d;
      press_q    <= press_d;
      hold_act_q <= hold_act_d;
      dbl_q      <= dbl_d;
      up_q       <= up_d;
      rel_q      <= rel_d;
      kind_q     <= kind_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign key_phase_o      = phase_q;
  assign press_event_o    = press_q;
  assign hold_active_o    = hold_act_q;
  assign double_click_o   = dbl_q;
  assign up_event_o       = up_q;
  assign released_level_o = rel_q;
  assign click_kind_o     = kind_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bchd_checker.sv =====
// Port-level checker for the button click / hold detector, with its bind.
`default_nettype none

module bchd_checker
  import bchd_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [1:0]           key_phase_o,
  input wire logic                 press_event_o,
  input wire logic                 hold_active_o,
  input wire logic                 double_click_o,
  input wire logic                 up_event_o,
  input wire logic                 released_level_o,
  input wire logic [1:0]           click_kind_o
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_phase_o)
      && $stable(click_kind_o) && $stable(hold_active_o))
    else $error("stalled result changed");

  // Empty output register never stalls the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  // Edge flags follow the phase
  a_flags_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (press_event_o == (key_phase_o == PHASE_DOWN))
      && (up_event_o == (key_phase_o == PHASE_UP))
      && (released_level_o == (key_phase_o == PHASE_HIGH)))
    else $error("edge flag does not match phase");

  // Hold only while pressed; clicks only on a down edge
  a_hold_clicks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!hold_active_o || key_phase_o == PHASE_LOW)
      && (click_kind_o == KIND_NONE || key_phase_o == PHASE_DOWN))
    else $error("hold or click outside its phase");

  // Double click flag agrees with the click kind
  a_double_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> double_click_o == (click_kind_o == KIND_DOUBLE))
    else $error("double click flag and kind disagree");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (.*);

`default_nettype wire
